// ----- rtl/matrix4_inverse_cofactor_assert.svh -----
// Assertion macros used by the checker of the matrix inverse block.
`ifndef MATRIX4_INVERSE_COFACTOR_ASSERT_SVH
`define MATRIX4_INVERSE_COFACTOR_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define MI4_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mi4 check failed");

// The consequent holds in the cycle after the antecedent.
`define MI4_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mi4 check failed");

`endif

// ----- rtl/mi4_pkg.sv -----
package mi4_pkg;

    typedef enum logic [9:0] {
        S_LOAD   = 10'b0000000001,
        S_FETCH  = 10'b0000000010,
        S_MSTART = 10'b0000000100,
        S_MWAIT  = 10'b0000001000,
        S_ADJW   = 10'b0000010000,
        S_CHECK  = 10'b0000100000,
        S_DFETCH = 10'b0001000000,
        S_DSTART = 10'b0010000000,
        S_DWAIT  = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } state_t;

    typedef enum logic [1:0] {
        PH_PAIR1  = 2'd0,
        PH_PAIR2  = 2'd1,
        PH_TRIPLE = 2'd2
    } phase_t;

    localparam logic [3:0] LAST_INDEX = 4'd15;
    localparam logic [1:0] LAST_TERM  = 2'd2;
    localparam logic [1:0] LAST_COL   = 2'd3;

    function automatic logic [1:0] next3(input logic [1:0] j);
        logic [1:0] r;
        r = (j == LAST_TERM) ? 2'd0 : j + 2'd1;
        return r;
    endfunction

    // Address of element (i, jj) of the 3x3 minor that belongs to adjugate
    // position k; the minor drops row k[3:2] and column k[1:0].
    function automatic logic [3:0] minor_addr(input logic [3:0] k, input logic [1:0] i,
                                              input logic [1:0] jj);
        logic [1:0] row;
        logic [1:0] col;
        row = (i >= k[3:2]) ? i + 2'd1 : i;
        col = (jj >= k[1:0]) ? jj + 2'd1 : jj;
        return {col, row};
    endfunction

endpackage

// ----- rtl/mi4_mul.sv -----
module mi4_mul #(
    parameter int AW = 99,
    parameter int BW = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [AW+BW-1:0] prod,
    output logic                 done
);

    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW);

    logic signed [PW-1:0] mcand_reg;
    logic signed [PW-1:0] acc_reg;
    logic [BW-1:0]        mplier_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 last;

    assign last = (cnt_reg == CW'(BW - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && last;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg  <= PW'(a);
            mplier_reg <= b;
            acc_reg    <= '0;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_reg <= last ? acc_reg - mcand_reg : acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

// ----- rtl/mi4_div.sv -----
module mi4_div #(
    parameter int NW = 131,
    parameter int DW = 133
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo,
    output logic          done
);

    localparam int CW = $clog2(NW);

    logic [NW-1:0] work_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic          last;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign last  = (cnt_reg == CW'(NW - 1));
    assign trial = {rem_reg, work_reg[NW-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && last;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end else if (busy_reg) begin
            rem_reg  <= ge ? diff[DW-1:0] : trial[DW-1:0];
            work_reg <= {work_reg[NW-2:0], ge};
        end
    end

    assign quo  = work_reg;
    assign done = done_reg;

endmodule

// ----- rtl/matrix4_inverse_cofactor.sv -----
// 4x4 matrix inverse by adjugate over determinant, in signed fixed point with
// FRAC_BITS fractional bits. Sixteen element beats are taken in column-major
// order, one per cycle while s_ready is high; then the block computes the
// adjugate and determinant with one shared shift-add multiplier (148 products:
// nine for each of the sixteen cofactors and four for the determinant) and
// divides each adjugate entry by the determinant with one restoring divider
// that retires one quotient bit per cycle (3*ELEMENT_WIDTH + 3 + 2*FRAC_BITS
// bits per element). Results come out as sixteen beats in column-major order,
// truncated toward zero and saturated, with m_last on the final beat. A zero
// determinant gives the identity with m_singular set.
module matrix4_inverse_cofactor
    import mi4_pkg::*;
#(
    parameter int ELEMENT_WIDTH = 32,
    parameter int FRAC_BITS     = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [ELEMENT_WIDTH-1:0] s_element_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [ELEMENT_WIDTH-1:0] m_inverse_value,
    output logic [3:0]                      m_element_index,
    output logic                            m_singular,
    output logic                            m_last
);

    localparam int EW = ELEMENT_WIDTH;
    localparam int AW = 3 * EW + 3;
    localparam int PW = AW + EW;
    localparam int DW = 4 * EW + 5;
    localparam int NW = AW + 2 * FRAC_BITS;
    localparam logic [EW-1:0] MAX_POS = {1'b0, {(EW - 1){1'b1}}};
    localparam logic [EW-1:0] ONE_VAL =
        (FRAC_BITS >= EW - 1) ? MAX_POS : (EW'(1) << FRAC_BITS);

    state_t state_reg, state_next;
    phase_t ph_reg, ph_next;
    logic [3:0] load_cnt_reg, load_cnt_next;
    logic [3:0] k_reg, k_next;
    logic [1:0] j_reg, j_next;
    logic       det_mode_reg, det_mode_next;
    logic       singular_reg, singular_next;
    logic       neg_reg, neg_next;
    logic       m_valid_reg, m_valid_next;

    logic signed [EW-1:0]   elem_mem [16];
    logic signed [AW-1:0]   adj_mem [16];
    logic signed [EW-1:0]   rd_a_reg;
    logic signed [EW-1:0]   rd_b_reg;
    logic signed [AW-1:0]   adj_rd_reg;
    logic signed [2*EW-1:0] p1_reg;
    logic signed [2*EW:0]   diff_reg;
    logic signed [AW-1:0]   acc_reg;
    logic signed [DW-1:0]   det_reg;
    logic [EW-1:0]          val_reg;
    logic [EW-1:0]          out_val_reg;
    logic [3:0]             out_idx_reg;
    logic                   out_sing_reg;
    logic                   out_last_reg;

    logic [1:0]           ja;
    logic [1:0]           jb;
    logic [3:0]           addr_a;
    logic [3:0]           addr_b;
    logic                 in_fire;
    logic                 adj_we;
    logic signed [AW-1:0] adj_wdata;
    logic                 out_load;

    logic                   mul_start;
    logic                   mul_done;
    logic signed [AW-1:0]   mul_a;
    logic signed [PW-1:0]   mul_prod;
    logic signed [2*EW-1:0] prod_small;

    logic                 div_start;
    logic                 div_done;
    logic [AW-1:0]        adj_mag;
    logic [DW-1:0]        det_mag;
    logic [NW-1:0]        div_num;
    logic [NW-1:0]        div_quo;
    logic                 over_pos;
    logic                 over_neg;
    logic [EW-1:0]        sat_val;
    logic [EW-1:0]        id_val;

    assign in_fire = s_valid && s_ready;
    assign s_ready = (state_reg == S_LOAD);

    assign ja = next3(j_reg);
    assign jb = next3(ja);

    always_comb begin
        addr_a = (ph_reg == PH_PAIR2) ? minor_addr(k_reg, 2'd1, jb)
                                      : minor_addr(k_reg, 2'd1, ja);
        if (det_mode_reg) begin
            addr_b = {k_reg[1:0], 2'b00};
        end else begin
            unique case (ph_reg)
                PH_PAIR1: addr_b = minor_addr(k_reg, 2'd2, jb);
                PH_PAIR2: addr_b = minor_addr(k_reg, 2'd2, ja);
                default:  addr_b = minor_addr(k_reg, 2'd0, j_reg);
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            elem_mem[load_cnt_reg] <= s_element_value;
        end
        rd_a_reg <= elem_mem[addr_a];
        rd_b_reg <= elem_mem[addr_b];
    end

    assign adj_wdata = (k_reg[0] ^ k_reg[2]) ? -acc_reg : acc_reg;

    always_ff @(posedge aclk) begin
        if (adj_we) begin
            adj_mem[k_reg] <= adj_wdata;
        end
        adj_rd_reg <= adj_mem[k_reg];
    end

    always_comb begin
        if (det_mode_reg) begin
            mul_a = adj_rd_reg;
        end else if (ph_reg == PH_TRIPLE) begin
            mul_a = AW'(diff_reg);
        end else begin
            mul_a = AW'(rd_a_reg);
        end
    end

    mi4_mul #(.AW(AW), .BW(EW)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (rd_b_reg),
        .prod    (mul_prod),
        .done    (mul_done)
    );

    assign prod_small = mul_prod[2*EW-1:0];

    assign adj_mag = adj_rd_reg[AW-1] ? AW'(-adj_rd_reg) : AW'(adj_rd_reg);
    assign det_mag = det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
    assign div_num = {adj_mag, {(2 * FRAC_BITS){1'b0}}};

    mi4_div #(.NW(NW), .DW(DW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (det_mag),
        .quo     (div_quo),
        .done    (div_done)
    );

    assign over_pos = |div_quo[NW-1:EW-1];
    assign over_neg = (|div_quo[NW-1:EW]) || (div_quo[EW-1] && (|div_quo[EW-2:0]));

    always_comb begin
        if (neg_reg) begin
            sat_val = over_neg ? ~MAX_POS : EW'(-div_quo[EW-1:0]);
        end else begin
            sat_val = over_pos ? MAX_POS : div_quo[EW-1:0];
        end
    end

    assign id_val = (k_reg[1:0] == k_reg[3:2]) ? ONE_VAL : '0;

    always_comb begin
        state_next    = state_reg;
        ph_next       = ph_reg;
        load_cnt_next = load_cnt_reg;
        k_next        = k_reg;
        j_next        = j_reg;
        det_mode_next = det_mode_reg;
        singular_next = singular_reg;
        neg_next      = neg_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        mul_start     = 1'b0;
        div_start     = 1'b0;
        adj_we        = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            S_LOAD: begin
                if (in_fire) begin
                    load_cnt_next = load_cnt_reg + 4'd1;
                    if (load_cnt_reg == LAST_INDEX) begin
                        k_next        = '0;
                        j_next        = '0;
                        ph_next       = PH_PAIR1;
                        det_mode_next = 1'b0;
                        state_next    = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                state_next = S_MSTART;
            end
            S_MSTART: begin
                mul_start  = 1'b1;
                state_next = S_MWAIT;
            end
            S_MWAIT: begin
                if (mul_done) begin
                    state_next = S_FETCH;
                    if (det_mode_reg) begin
                        k_next = k_reg + 4'd1;
                        if (k_reg[1:0] == LAST_COL) begin
                            state_next = S_CHECK;
                        end
                    end else begin
                        unique case (ph_reg)
                            PH_PAIR1: ph_next = PH_PAIR2;
                            PH_PAIR2: ph_next = PH_TRIPLE;
                            default: begin
                                ph_next = PH_PAIR1;
                                j_next  = ja;
                                if (j_reg == LAST_TERM) begin
                                    state_next = S_ADJW;
                                end
                            end
                        endcase
                    end
                end
            end
            S_ADJW: begin
                adj_we     = 1'b1;
                k_next     = k_reg + 4'd1;
                state_next = S_FETCH;
                if (k_reg == LAST_INDEX) begin
                    det_mode_next = 1'b1;
                end
            end
            S_CHECK: begin
                k_next        = '0;
                singular_next = (det_reg == '0);
                state_next    = (det_reg == '0) ? S_OUT : S_DFETCH;
            end
            S_DFETCH: begin
                state_next = S_DSTART;
            end
            S_DSTART: begin
                div_start  = 1'b1;
                neg_next   = adj_rd_reg[AW-1] ^ det_reg[DW-1];
                state_next = S_DWAIT;
            end
            S_DWAIT: begin
                if (div_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    k_next       = k_reg + 4'd1;
                    if (k_reg == LAST_INDEX) begin
                        state_next = S_LOAD;
                    end else begin
                        state_next = singular_reg ? S_OUT : S_DFETCH;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            ph_reg       <= PH_PAIR1;
            load_cnt_reg <= '0;
            k_reg        <= '0;
            j_reg        <= '0;
            det_mode_reg <= 1'b0;
            singular_reg <= 1'b0;
            neg_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ph_reg       <= ph_next;
            load_cnt_reg <= load_cnt_next;
            k_reg        <= k_next;
            j_reg        <= j_next;
            det_mode_reg <= det_mode_next;
            singular_reg <= singular_next;
            neg_reg      <= neg_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_MWAIT && mul_done) begin
            if (det_mode_reg) begin
                det_reg <= det_reg + DW'(mul_prod);
            end else begin
                unique case (ph_reg)
                    PH_PAIR1: p1_reg   <= prod_small;
                    PH_PAIR2: diff_reg <= (2*EW+1)'(p1_reg) - (2*EW+1)'(prod_small);
                    default:  acc_reg  <= acc_reg + AW'(mul_prod);
                endcase
            end
        end
        if (state_reg == S_LOAD) begin
            acc_reg <= '0;
            det_reg <= '0;
        end
        if (adj_we) begin
            acc_reg <= '0;
        end
        if (state_reg == S_DWAIT && div_done) begin
            val_reg <= sat_val;
        end
        if (out_load) begin
            out_val_reg  <= singular_reg ? id_val : val_reg;
            out_idx_reg  <= k_reg;
            out_sing_reg <= singular_reg;
            out_last_reg <= (k_reg == LAST_INDEX);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_inverse_value = out_val_reg;
    assign m_element_index = out_idx_reg;
    assign m_singular      = out_sing_reg;
    assign m_last          = out_last_reg;

endmodule

// ----- rtl/mi4_checker.sv -----
`include "matrix4_inverse_cofactor_assert.svh"

module mi4_checker #(
    parameter int ELEMENT_WIDTH = 32
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic signed [ELEMENT_WIDTH-1:0] m_inverse_value,
    input logic [3:0]                      m_element_index,
    input logic                            m_last
);

    // A stalled result beat keeps its value.
    `MI4_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_inverse_value))
    `MI4_ASSERT_IMP(a_last_index, m_valid && m_last, m_element_index == 4'd15)
    // No new matrix is taken while earlier beats of a result remain.
    `MI4_ASSERT_IMP(a_no_load_mid, m_valid && !m_last, !s_ready)
    `MI4_ASSERT_NEXT(a_gap_after_last, m_valid && m_ready && m_last, !m_valid)

endmodule

bind matrix4_inverse_cofactor mi4_checker #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_mi4_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_inverse_value (m_inverse_value),
    .m_element_index (m_element_index),
    .m_last          (m_last)
);

// ----- verif/matrix4_inverse_cofactor_tb.sv -----
module matrix4_inverse_cofactor_tb;
    import mi4_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [191:0] wide_t;

    typedef struct {
        logic signed [31:0] inverse_value;
        logic [3:0]         element_index;
        logic               singular;
        logic               last;
    } inverse_beat_t;

    localparam logic signed [31:0] MAX_VAL = 32'sh7fffffff;
    localparam logic signed [31:0] MIN_VAL = 32'sh80000000;
    localparam logic signed [31:0] ONE_Q16 = 32'sh00010000;
    localparam int                 MATRIX_LEN = 16;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_element_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_inverse_value;
    logic [3:0]         m_element_index;
    logic               m_singular;
    logic               m_last;

    inverse_beat_t      pending_inverse[$];
    logic signed [31:0] matrix_elems[16];
    int                 load_pos = 0;
    int                 error_count = 0;
    int                 beats_checked = 0;
    int                 matrices_sent = 0;
    int                 singular_seen = 0;
    bit                 no_idle = 1'b0;
    int                 ready_hold = 0;

    matrix4_inverse_cofactor dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_element_value (s_element_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_inverse_value (m_inverse_value),
        .m_element_index (m_element_index),
        .m_singular      (m_singular),
        .m_last          (m_last)
    );

    always #4 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic wide_t elem_at(int row, int col);
        wide_t w;
        w = matrix_elems[row + 4 * col];
        return w;
    endfunction

    function automatic wide_t minor_det(int skip_row, int skip_col);
        wide_t m[3][3];
        int rows[3];
        int cols[3];
        int n;
        n = 0;
        for (int i = 0; i < 4; i++) if (i != skip_row) rows[n++] = i;
        n = 0;
        for (int i = 0; i < 4; i++) if (i != skip_col) cols[n++] = i;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) m[i][j] = elem_at(rows[i], cols[j]);
        return m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
             - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
             + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
    endfunction

    task automatic predict_inverse();
        wide_t adj[16];
        wide_t det;
        wide_t quot;
        inverse_beat_t b;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) begin
                adj[r + 4 * c] = minor_det(c, r);
                if ((r + c) % 2 == 1) adj[r + 4 * c] = -adj[r + 4 * c];
            end
        det = '0;
        for (int c = 0; c < 4; c++) det = det + elem_at(0, c) * adj[c];
        for (int k = 0; k < 16; k++) begin
            b.element_index = 4'(k);
            b.singular = (det == 0);
            b.last = (k == 15);
            if (det == 0) begin
                b.inverse_value = (k % 5 == 0) ? ONE_Q16 : 32'sd0;
            end else begin
                quot = (adj[k] <<< 32) / det;
                if (quot > wide_t'(MAX_VAL)) b.inverse_value = MAX_VAL;
                else if (quot < wide_t'(MIN_VAL)) b.inverse_value = MIN_VAL;
                else b.inverse_value = quot[31:0];
            end
            pending_inverse.push_back(b);
        end
        if (det == 0) singular_seen++;
    endtask

    task automatic send_element(logic signed [31:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_element_value <= value;
        do @(posedge aclk); while (!s_ready);
        matrix_elems[load_pos] = value;
        load_pos++;
        if (load_pos == MATRIX_LEN) begin
            load_pos = 0;
            matrices_sent++;
            predict_inverse();
        end
    endtask

    task automatic send_matrix(logic signed [31:0] m[16]);
        for (int i = 0; i < MATRIX_LEN; i++) send_element(m[i]);
    endtask

    task automatic test_identity();
        logic signed [31:0] m[16];
        for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? ONE_Q16 : 32'sd0;
        send_matrix(m);
        for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? -32'sh00020000 : 32'sd0;
        m[12] = 32'sh00030000;
        send_matrix(m);
    endtask

    task automatic test_singular();
        logic signed [31:0] m[16];
        for (int i = 0; i < 16; i++) m[i] = 32'sd0;
        send_matrix(m);
        for (int i = 0; i < 16; i++) m[i] = MAX_VAL;
        send_matrix(m);
    endtask

    task automatic test_saturation();
        logic signed [31:0] m[16];
        for (int i = 0; i < 16; i++) m[i] = 32'sd0;
        m[0] = 32'sd1;
        m[5] = -32'sd1;
        m[10] = MAX_VAL;
        m[15] = MIN_VAL;
        send_matrix(m);
        for (int i = 0; i < 16; i++) m[i] = ((i + i / 4) % 2 == 0) ? MAX_VAL : MIN_VAL;
        m[3] = 32'sd0;
        m[6] = 32'sd1;
        send_matrix(m);
    endtask

    task automatic test_random(int count);
        logic signed [31:0] m[16];
        int kind;
        int src;
        int dst;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 3);
            no_idle = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < 16; i++) begin
                case (kind)
                    0: m[i] = $urandom;
                    1, 2: m[i] = $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
                    default: m[i] = ((i % 5 == 0) ? $signed($urandom_range(1, 32'h7ffff))
                                                  : 32'sd0)
                                    + $signed($urandom_range(0, 32'h1000)) - 32'sh800;
                endcase
            end
            if (kind == 2) begin
                src = $urandom_range(0, 3);
                dst = (src + $urandom_range(1, 3)) % 4;
                for (int r = 0; r < 4; r++) m[r + 4 * dst] = m[r + 4 * src];
            end
            send_matrix(m);
        end
        no_idle = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn || no_idle) begin
            m_ready <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            ready_hold <= pick_gap();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        inverse_beat_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_inverse.size() == 0) begin
                $display("%0t: unexpected beat value=%0d index=%0d", $realtime,
                         m_inverse_value, m_element_index);
                error_count++;
            end else begin
                e = pending_inverse.pop_front();
                beats_checked++;
                if (m_inverse_value !== e.inverse_value || m_element_index !== e.element_index
                        || m_singular !== e.singular || m_last !== e.last) begin
                    $display("%0t: expected value=%0d index=%0d singular=%0b last=%0b",
                             $realtime, e.inverse_value, e.element_index, e.singular, e.last);
                    $display("%0t: actual   value=%0d index=%0d singular=%0b last=%0b",
                             $realtime, m_inverse_value, m_element_index, m_singular, m_last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("matrix4_inverse_cofactor: mismatch");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_identity();
        test_singular();
        test_saturation();
        test_random(24);
        s_valid <= 1'b0;
        while (pending_inverse.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("Sent %0d matrices (%0d singular), checked %0d result beats.",
                 matrices_sent, singular_seen, beats_checked);
        if (error_count == 0 && pending_inverse.size() == 0) begin
            $display("matrix4_inverse_cofactor: match");
        end else begin
            $display("matrix4_inverse_cofactor: mismatch");
        end
        $finish;
    end

endmodule
